[rtl/two_group_lowest_free_slot_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the two-group slot allocator
// Clocked on i_clk and held off while i_rst_n is low. They expand to nothing
// in synthesis.
// ----------------------------------------------------------------------------
`ifndef TWO_GROUP_LOWEST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define TWO_GROUP_LOWEST_FREE_SLOT_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LFSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define LFSA_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define LFSA_ASSERT(lbl, prop, msg)
`define LFSA_NEVER(lbl, expr, msg)
`endif

`endif

[rtl/lfsa_pkg.sv]
// ----------------------------------------------------------------------------
// lfsa_pkg
// Widths, controller states and control/status bundles of the allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    localparam int SLOT_W = 5;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 16;
    localparam int BEST_W = 17;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] SLOTS_RST = 5'd16;
    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_INC,
        S_WAIT,
        S_INIT,
        S_P1_RD,
        S_P1_ACC,
        S_P2_RD,
        S_P2_ACC
    } t_state;

    typedef struct packed {
        logic load_in;
        logic alloc;
        logic incr;
        logic init;
        logic p1_rd;
        logic p1_acc;
        logic p2_rd;
        logic p2_acc;
        logic load_out;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_free;
        logic j_done;
        logic k_done;
    } t_sts;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

[rtl/lfsa_dp.sv]
// ----------------------------------------------------------------------------
// lfsa_dp
// Datapath: slot busy/release store, lowest-free encoder, grant count
// memories, prefix memory for the split scan, config and output registers.
// ----------------------------------------------------------------------------
module lfsa_dp #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lfsa_pkg::t_cmd               i_cmd,
    output lfsa_pkg::t_sts               o_sts,
    input  logic                         i_cfg_valid,
    input  logic [lfsa_pkg::CFG_W-1:0]   i_slots_in_use,
    input  logic                         i_group,
    input  logic [lfsa_pkg::TIME_W-1:0]  i_arrival_time,
    input  logic [lfsa_pkg::TIME_W-1:0]  i_departure_time,
    input  logic                         i_last_item,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_granted,
    output logic [lfsa_pkg::SLOT_W-1:0]  o_slot,
    output logic [lfsa_pkg::BEST_W-1:0]  o_best_total,
    output logic                         o_done_res
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int NW = $clog2(MAX_SLOTS + 1);
    localparam int PD = MAX_SLOTS + 1;
    localparam int CW = lfsa_pkg::CNT_W;
    localparam int BW = lfsa_pkg::BEST_W;

    logic [lfsa_pkg::CFG_W-1:0]  r_slots_in_use;
    logic                        r_group;
    logic [lfsa_pkg::TIME_W-1:0] r_arr;
    logic [lfsa_pkg::TIME_W-1:0] r_dep;
    logic                        r_last;

    logic [MAX_SLOTS-1:0]        r_busy [2];
    logic [lfsa_pkg::TIME_W-1:0] r_rel  [2][MAX_SLOTS];
    logic                        r_grant;
    logic [IW-1:0]               r_idx;

    logic [CW-1:0]               r_cnt0_mem [MAX_SLOTS];
    logic [CW-1:0]               r_cnt1_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]        r_cnt0_vld;
    logic [MAX_SLOTS-1:0]        r_cnt1_vld;
    logic [CW-1:0]               r_c0_q;
    logic [CW-1:0]               r_c1_q;
    logic                        r_c0_v;
    logic                        r_c1_v;

    logic [CW-1:0]               r_pmem [PD];
    logic [CW-1:0]               r_p_q;

    logic [NW-1:0]               r_j;
    logic [NW-1:0]               r_k;
    logic [CW-1:0]               r_acc0;
    logic [CW-1:0]               r_acc1;
    logic [BW-1:0]               r_best;

    logic                        r_out_valid;
    logic                        r_o_granted;
    logic [lfsa_pkg::SLOT_W-1:0] r_o_slot;
    logic [BW-1:0]               r_o_best;
    logic                        r_o_done;

    logic [NW-1:0]               n_slots;
    logic [MAX_SLOTS-1:0]        cur_busy;
    logic [MAX_SLOTS-1:0]        expired;
    logic [MAX_SLOTS-1:0]        kept;
    logic [MAX_SLOTS-1:0]        cand;
    logic [MAX_SLOTS-1:0]        grant_vec;
    logic [IW-1:0]               enc_idx;
    logic                        enc_hit;
    logic [IW-1:0]               rd_addr;
    logic [NW-1:0]               pr_addr;
    logic                        pw_en;
    logic [NW-1:0]               pw_addr;
    logic [CW-1:0]               pw_data;
    logic [CW-1:0]               c0_data;
    logic [CW-1:0]               c1_data;
    logic [CW-1:0]               inc_val;
    logic [CW-1:0]               acc1_next;
    logic [BW-1:0]               total;
    logic                        j_done;
    logic                        k_done;

    assign n_slots = (32'(r_slots_in_use) > 32'(MAX_SLOTS)) ? NW'(MAX_SLOTS)
                                                           : NW'(r_slots_in_use);
    assign j_done  = (r_j == n_slots);
    assign k_done  = (r_k == n_slots);

    // free expired slots, then pick the lowest free one below the slot count
    always_comb begin
        cur_busy  = r_busy[r_group];
        for (int i = 0; i < MAX_SLOTS; i++) begin
            expired[i] = cur_busy[i] && (r_rel[r_group][i] <= r_arr);
        end
        kept = cur_busy & ~expired;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            cand[i] = !kept[i] && (NW'(i) < n_slots);
        end
        enc_hit = |cand;
        enc_idx = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                enc_idx = IW'(i);
            end
        end
        grant_vec = '0;
        if (enc_hit) begin
            grant_vec[enc_idx] = 1'b1;
        end
    end

    always_comb begin
        rd_addr = '0;
        if (i_cmd.alloc) begin
            rd_addr = enc_idx;
        end else if (i_cmd.p1_rd && !j_done) begin
            rd_addr = r_j[IW-1:0];
        end else if (i_cmd.p2_rd && !k_done) begin
            rd_addr = r_k[IW-1:0];
        end
    end

    assign c0_data   = r_c0_v ? r_c0_q : '0;
    assign c1_data   = r_c1_v ? r_c1_q : '0;
    assign inc_val   = lfsa_pkg::sat_add(r_group ? c1_data : c0_data, CW'(1));
    assign acc1_next = lfsa_pkg::sat_add(r_acc1, c1_data);
    assign total     = {1'b0, r_acc0} + {1'b0, r_p_q};
    assign pr_addr   = n_slots - r_k;

    always_comb begin
        pw_en   = i_cmd.init || i_cmd.p1_acc;
        pw_addr = i_cmd.init ? '0 : NW'(r_j + 1'b1);
        pw_data = i_cmd.init ? '0 : acc1_next;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= lfsa_pkg::SLOTS_RST;
        end else if (i_cfg_valid) begin
            r_slots_in_use <= i_slots_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_group <= i_group;
            r_arr   <= i_arrival_time;
            r_dep   <= i_departure_time;
            r_last  <= i_last_item;
        end
        if (i_cmd.alloc) begin
            r_grant <= enc_hit;
            r_idx   <= enc_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '{default: '0};
        end else if (i_cmd.clear) begin
            r_busy <= '{default: '0};
        end else if (i_cmd.alloc) begin
            r_busy[r_group] <= kept | grant_vec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc && enc_hit) begin
            r_rel[r_group][enc_idx] <= r_dep;
        end
    end

    // grant count memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.incr && r_grant) begin
            if (r_group) begin
                r_cnt1_mem[r_idx] <= inc_val;
            end else begin
                r_cnt0_mem[r_idx] <= inc_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c0_q <= r_cnt0_mem[rd_addr];
        r_c1_q <= r_cnt1_mem[rd_addr];
        r_c0_v <= r_cnt0_vld[rd_addr];
        r_c1_v <= r_cnt1_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt0_vld <= '0;
            r_cnt1_vld <= '0;
        end else if (i_cmd.clear) begin
            r_cnt0_vld <= '0;
            r_cnt1_vld <= '0;
        end else if (i_cmd.incr && r_grant) begin
            if (r_group) begin
                r_cnt1_vld[r_idx] <= 1'b1;
            end else begin
                r_cnt0_vld[r_idx] <= 1'b1;
            end
        end
    end

    // prefix sums of group 1
    always_ff @(posedge i_clk) begin
        if (pw_en) begin
            r_pmem[pw_addr] <= pw_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_q <= r_pmem[pr_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j    <= '0;
            r_k    <= '0;
            r_acc0 <= '0;
            r_acc1 <= '0;
            r_best <= '0;
        end else if (i_cmd.init) begin
            r_j    <= '0;
            r_k    <= '0;
            r_acc0 <= '0;
            r_acc1 <= '0;
            r_best <= '0;
        end else if (i_cmd.p1_acc) begin
            r_acc1 <= acc1_next;
            r_j    <= NW'(r_j + 1'b1);
        end else if (i_cmd.p2_acc) begin
            if (total > r_best) begin
                r_best <= total;
            end
            r_acc0 <= lfsa_pkg::sat_add(r_acc0, c0_data);
            if (!k_done) begin
                r_k <= NW'(r_k + 1'b1);
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_granted <= r_grant;
            r_o_slot    <= r_grant ? lfsa_pkg::SLOT_W'(r_idx) + lfsa_pkg::SLOT_W'(1) : '0;
            r_o_best    <= r_last ? r_best : '0;
            r_o_done    <= r_last;
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.j_done   = j_done;
    assign o_sts.k_done   = k_done;

    assign o_out_valid  = r_out_valid;
    assign o_granted    = r_o_granted;
    assign o_slot       = r_o_slot;
    assign o_best_total = r_o_best;
    assign o_done_res   = r_o_done;

endmodule

[rtl/lfsa_ctrl.sv]
// ----------------------------------------------------------------------------
// lfsa_ctrl
// Sequencer: accept, allocate, count write, and the two-pass split scan
// on the last word.
// ----------------------------------------------------------------------------
module lfsa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  lfsa_pkg::t_sts i_sts,
    output logic           o_in_stall,
    output lfsa_pkg::t_cmd o_cmd
);

    lfsa_pkg::t_state r_state;
    lfsa_pkg::t_state n_state;
    logic             can_take;
    logic             can_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfsa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        can_emit = ((r_state == lfsa_pkg::S_INC && !i_sts.last) ||
                    r_state == lfsa_pkg::S_WAIT) && i_sts.out_free;
        can_take = (r_state == lfsa_pkg::S_IDLE) || can_emit;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfsa_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lfsa_pkg::S_ALLOC;
            end
            lfsa_pkg::S_ALLOC: begin
                n_state = lfsa_pkg::S_INC;
            end
            lfsa_pkg::S_INC: begin
                if (i_sts.last) begin
                    n_state = lfsa_pkg::S_INIT;
                end else if (i_sts.out_free) begin
                    n_state = i_in_valid ? lfsa_pkg::S_ALLOC : lfsa_pkg::S_IDLE;
                end else begin
                    n_state = lfsa_pkg::S_WAIT;
                end
            end
            lfsa_pkg::S_WAIT: begin
                if (i_sts.out_free) begin
                    n_state = i_in_valid ? lfsa_pkg::S_ALLOC : lfsa_pkg::S_IDLE;
                end
            end
            lfsa_pkg::S_INIT: begin
                n_state = lfsa_pkg::S_P1_RD;
            end
            lfsa_pkg::S_P1_RD: begin
                n_state = i_sts.j_done ? lfsa_pkg::S_P2_RD : lfsa_pkg::S_P1_ACC;
            end
            lfsa_pkg::S_P1_ACC: begin
                n_state = lfsa_pkg::S_P1_RD;
            end
            lfsa_pkg::S_P2_RD: begin
                n_state = lfsa_pkg::S_P2_ACC;
            end
            lfsa_pkg::S_P2_ACC: begin
                n_state = i_sts.k_done ? lfsa_pkg::S_WAIT : lfsa_pkg::S_P2_RD;
            end
            default: begin
                n_state = lfsa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_stall     = !can_take;
        o_cmd.load_in  = can_take && i_in_valid;
        o_cmd.load_out = can_emit;
        unique case (r_state)
            lfsa_pkg::S_ALLOC:  o_cmd.alloc  = 1'b1;
            lfsa_pkg::S_INC:    o_cmd.incr   = 1'b1;
            lfsa_pkg::S_INIT:   o_cmd.init   = 1'b1;
            lfsa_pkg::S_P1_RD:  o_cmd.p1_rd  = 1'b1;
            lfsa_pkg::S_P1_ACC: o_cmd.p1_acc = 1'b1;
            lfsa_pkg::S_P2_RD:  o_cmd.p2_rd  = 1'b1;
            lfsa_pkg::S_P2_ACC: begin
                o_cmd.p2_acc = 1'b1;
                o_cmd.clear  = i_sts.k_done;
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/two_group_lowest_free_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// two_group_lowest_free_slot_allocator_unit
// Each word carries an interval tagged with group 0 or 1. The block frees
// every slot of that group whose held departure is not later than the
// arrival, grants the lowest free slot among 1..slots_in_use and counts the
// grant (counters saturate at 65535). An ordinary word passes through accept
// and then the encode state; its count write overlaps the next accept
// while the output is not stalled. A word marked last also runs the split
// scan over n effective slots: a count read and add per slot to build the
// group 1 prefix sums, then a prefix read and compare over all splits.
// Its result carries the best total and done_res, and all slot state is
// then cleared. No clearing pass after reset; configuration writes are
// always ready.
// ----------------------------------------------------------------------------
`include "two_group_lowest_free_slot_allocator_unit_macros.svh"

module two_group_lowest_free_slot_allocator_unit #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lfsa_pkg::CFG_W-1:0]   i_slots_in_use,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_group,
    input  logic [lfsa_pkg::TIME_W-1:0]  i_arrival_time,
    input  logic [lfsa_pkg::TIME_W-1:0]  i_departure_time,
    input  logic                         i_last_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_granted,
    output logic [lfsa_pkg::SLOT_W-1:0]  o_slot,
    output logic [lfsa_pkg::BEST_W-1:0]  o_best_total,
    output logic                         o_done_res
);

    lfsa_pkg::t_cmd w_cmd;
    lfsa_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    lfsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    lfsa_dp #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_cfg_valid      (i_cfg_valid),
        .i_slots_in_use   (i_slots_in_use),
        .i_group          (i_group),
        .i_arrival_time   (i_arrival_time),
        .i_departure_time (i_departure_time),
        .i_last_item      (i_last_item),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_granted        (o_granted),
        .o_slot           (o_slot),
        .o_best_total     (o_best_total),
        .o_done_res       (o_done_res)
    );

    `LFSA_ASSERT(a_slot_matches_grant, o_out_valid |-> (o_granted == (o_slot != '0)), "slot/grant mismatch")
    `LFSA_ASSERT(a_best_only_on_done, (o_out_valid && !o_done_res) |-> (o_best_total == '0), "best total without done")
    `LFSA_ASSERT(a_load_shows_word, w_cmd.load_out |=> o_out_valid, "loaded word not shown")
    `LFSA_NEVER(a_no_take_in_scan, (w_cmd.p1_acc || w_cmd.p2_acc) && !o_in_stall, "word taken during scan")

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the two-group lowest-free-slot allocator
// Drives intervals with random gaps on the input and random stalls on the
// output, and rewrites the slot count between jobs. A scoreboard keeps its own
// per-group slot banks and grant counters. It predicts each grant and each
// end-of-job split total, then checks every returned word field by field.
// Some jobs run with no gaps on either side.
// ----------------------------------------------------------------------------

localparam int NSLOT = 16;

typedef struct packed {
    logic                        group;
    logic [lfsa_pkg::TIME_W-1:0] arrival;
    logic [lfsa_pkg::TIME_W-1:0] departure;
    logic                        last;
} t_interval;

typedef struct packed {
    logic                        granted;
    logic [lfsa_pkg::SLOT_W-1:0] slot;
    logic [lfsa_pkg::BEST_W-1:0] best;
    logic                        done;
} t_grant;

class grant_scoreboard;
    logic [lfsa_pkg::CFG_W-1:0]  slots_cfg;
    logic                        busy [2][NSLOT];
    logic [lfsa_pkg::TIME_W-1:0] release_at [2][NSLOT];
    logic [lfsa_pkg::CNT_W-1:0]  grants [2][NSLOT];
    t_grant                      pending [$];
    int unsigned                 errors;

    function new();
        slots_cfg = lfsa_pkg::SLOTS_RST;
        errors    = 0;
        clear_banks();
    endfunction

    function void clear_banks();
        foreach (busy[g, i]) begin
            busy[g][i]       = 1'b0;
            release_at[g][i] = '0;
            grants[g][i]     = '0;
        end
    endfunction

    function logic [lfsa_pkg::CNT_W-1:0] prefix_grants(int g, int k);
        logic [lfsa_pkg::CNT_W:0] s;
        int i;
        s = '0;
        for (i = 0; i < k; i++) begin
            s = s + {1'b0, grants[g][i]};
            if (s > {1'b0, lfsa_pkg::CNT_MAX}) s = {1'b0, lfsa_pkg::CNT_MAX};
        end
        return s[lfsa_pkg::CNT_W-1:0];
    endfunction

    function void note_interval(t_interval iv);
        t_grant e;
        int n;
        int g;
        int i;
        int k;
        logic [lfsa_pkg::BEST_W-1:0] total;
        logic [lfsa_pkg::BEST_W-1:0] top;
        n = (int'(slots_cfg) > NSLOT) ? NSLOT : int'(slots_cfg);
        g = int'(iv.group);
        e = '0;
        for (i = 0; i < NSLOT; i++) begin
            if (busy[g][i] && release_at[g][i] <= iv.arrival) busy[g][i] = 1'b0;
        end
        for (i = 0; i < n && !e.granted; i++) begin
            if (!busy[g][i]) begin
                busy[g][i]       = 1'b1;
                release_at[g][i] = iv.departure;
                if (grants[g][i] != lfsa_pkg::CNT_MAX) grants[g][i]++;
                e.granted = 1'b1;
                e.slot    = lfsa_pkg::SLOT_W'(i + 1);
            end
        end
        if (iv.last) begin
            top = '0;
            for (k = 0; k <= n; k++) begin
                total = {1'b0, prefix_grants(0, k)} + {1'b0, prefix_grants(1, n - k)};
                if (total > top) top = total;
            end
            e.best = top;
            clear_banks();
        end
        e.done = iv.last;
        pending.push_back(e);
    endfunction

    task report(string msg);
        if (errors < 100) $display("%0t ERROR %s", $time, msg);
        errors++;
    endtask

    task check_grant(t_grant got);
        t_grant e;
        if (pending.size() == 0) begin
            report("result word with nothing pending");
        end else begin
            e = pending.pop_front();
            if (got.granted !== e.granted)
                report($sformatf("granted got %0b exp %0b", got.granted, e.granted));
            if (got.slot !== e.slot)
                report($sformatf("slot got %0d exp %0d", got.slot, e.slot));
            if (got.best !== e.best)
                report($sformatf("best_total got %0d exp %0d", got.best, e.best));
            if (got.done !== e.done)
                report($sformatf("done_res got %0b exp %0b", got.done, e.done));
        end
    endtask
endclass

module tb_top;

    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 80;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_cfg_valid      = 1'b0;
    logic [lfsa_pkg::CFG_W-1:0]   i_slots_in_use   = '0;
    logic                         i_in_valid       = 1'b0;
    logic                         i_group          = 1'b0;
    logic [lfsa_pkg::TIME_W-1:0]  i_arrival_time   = '0;
    logic [lfsa_pkg::TIME_W-1:0]  i_departure_time = '0;
    logic                         i_last_item      = 1'b0;
    logic                         i_out_stall      = 1'b0;
    logic                         o_cfg_ready;
    logic                         o_in_stall;
    logic                         o_out_valid;
    logic                         o_granted;
    logic [lfsa_pkg::SLOT_W-1:0]  o_slot;
    logic [lfsa_pkg::BEST_W-1:0]  o_best_total;
    logic                         o_done_res;

    bit              idle_on     = 1'b1;
    int unsigned     idle_cycles = 0;
    grant_scoreboard sb          = new();

    two_group_lowest_free_slot_allocator_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_slots_in_use   (i_slots_in_use),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_group          (i_group),
        .i_arrival_time   (i_arrival_time),
        .i_departure_time (i_departure_time),
        .i_last_item      (i_last_item),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_granted        (o_granted),
        .o_slot           (o_slot),
        .o_best_total     (o_best_total),
        .o_done_res       (o_done_res)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_interval(input logic g, input logic [31:0] arr,
                                 input logic [31:0] dep, input logic last);
        t_interval iv;
        int gap;
        iv = '{group: g, arrival: arr, departure: dep, last: last};
        i_group          <= g;
        i_arrival_time   <= arr;
        i_departure_time <= dep;
        i_last_item      <= last;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_interval(iv);
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_slots(input logic [lfsa_pkg::CFG_W-1:0] v);
        i_slots_in_use <= v;
        i_cfg_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.slots_cfg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // hold the sender until every pending word is back, then let the block settle
    task automatic end_phase();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin : drain_results
        t_grant got;
        int w;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            w = idle_on ? $urandom_range(0, 11) : 0;
            if (w != 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            got = '{granted: o_granted, slot: o_slot, best: o_best_total, done: o_done_res};
            sb.check_grant(got);
        end
    end

    initial begin : stimulus
        logic [31:0]                arr;
        logic [31:0]                dep;
        logic [31:0]                tnow [2];
        logic [lfsa_pkg::CFG_W-1:0] v;
        logic                       g;
        int                         j;
        int                         len;
        int                         span;
        int unsigned                rand_items;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset slot count, time extremes, out-of-order and degenerate times
        send_interval(1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0);
        send_interval(1'b0, 32'h0, 32'd5, 1'b0);
        send_interval(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_interval(1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_interval(1'b0, 32'd5, 32'd10, 1'b0);
        send_interval(1'b1, 32'h0, 32'd1, 1'b0);
        send_interval(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_interval(1'b0, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
        end_phase();

        // no slots: all refused, zero total
        write_slots(5'd0);
        send_interval(1'b0, 32'd1, 32'd2, 1'b0);
        send_interval(1'b1, 32'd1, 32'd2, 1'b0);
        send_interval(1'b0, 32'd3, 32'd4, 1'b1);
        end_phase();

        // two slots: fill group 0, refuse, then split
        write_slots(5'd2);
        send_interval(1'b0, 32'd10, 32'd100, 1'b0);
        send_interval(1'b0, 32'd11, 32'd100, 1'b0);
        send_interval(1'b0, 32'd12, 32'd50, 1'b0);
        send_interval(1'b1, 32'd0, 32'd1, 1'b0);
        send_interval(1'b1, 32'd0, 32'd1, 1'b1);
        end_phase();

        // count above the bank size, then shrink: upper slots keep state
        write_slots(5'd31);
        send_interval(1'b0, 32'd0, 32'd1000, 1'b0);
        send_interval(1'b0, 32'd0, 32'd1000, 1'b0);
        send_interval(1'b0, 32'd0, 32'd1000, 1'b0);
        end_phase();
        write_slots(5'd1);
        send_interval(1'b0, 32'd500, 32'd600, 1'b0);
        send_interval(1'b0, 32'd1000, 32'd2000, 1'b0);
        send_interval(1'b1, 32'd7, 32'd8, 1'b1);
        end_phase();

        rand_items = 0;
        while (rand_items < 1500) begin
            case ($urandom_range(0, 9))
                0:       v = 5'd0;
                1:       v = lfsa_pkg::CFG_W'($urandom_range(17, 31));
                2, 3:    v = lfsa_pkg::CFG_W'($urandom_range(9, 16));
                default: v = lfsa_pkg::CFG_W'($urandom_range(1, 8));
            endcase
            write_slots(v);
            idle_on = ($urandom_range(0, 3) != 0);
            span    = (int'(v) > NSLOT) ? NSLOT : ((v == 0) ? 1 : int'(v));
            len     = $urandom_range(4, 40);
            tnow[0] = $urandom() >> $urandom_range(0, 31);
            tnow[1] = $urandom() >> $urandom_range(0, 31);
            for (j = 0; j < len; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    g   = 1'($urandom_range(0, 1));
                    arr = $urandom();
                    dep = $urandom();
                end else begin
                    g       = 1'($urandom_range(0, 1));
                    arr     = tnow[g] + $urandom_range(0, 3);
                    tnow[g] = arr;
                    dep     = arr + $urandom_range(1, 3 * span + 6);
                end
                send_interval(g, arr, dep, j == len - 1);
                rand_items++;
                if (j != len - 1 && $urandom_range(0, 39) == 0) end_phase();
            end
            end_phase();
        end

        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
